FILE: rtl/rne_pkg.sv
package rne_pkg;

    localparam int unsigned NUM_W   = 12;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned TBL_LEN = 13;
    localparam int unsigned IDX_W   = 4;

    localparam logic [NUM_W-1:0] MAX_NUMBER = 12'd3999;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;
    localparam logic [CHAR_W-1:0] NO_SYM = 8'd0;

    // Greedy subtractive table, largest weight first
    localparam logic [NUM_W-1:0] C_WEIGHT [TBL_LEN] = '{
        12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
        12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
    };

    // Upper-case symbols; second symbol is NO_SYM for single-letter entries
    localparam logic [CHAR_W-1:0] C_SYM0 [TBL_LEN] = '{
        "M", "C", "D", "C", "C", "X", "L", "X", "X", "I", "V", "I", "I"
    };
    localparam logic [CHAR_W-1:0] C_SYM1 [TBL_LEN] = '{
        NO_SYM, "M", NO_SYM, "D", NO_SYM, "C", NO_SYM, "L", NO_SYM, "X",
        NO_SYM, "V", NO_SYM
    };

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture a new number
        logic step;     // one table step, emits a letter on a hit
        logic err;      // emit the out-of-range beat
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic in_range;   // incoming number lies in 1..3999
        logic done;       // this step emits the final letter
        logic slot_free;  // output register can take a beat
    } t_sts;

endpackage

FILE: rtl/rne_ctrl.sv
module rne_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rne_pkg::t_sts i_sts,
    output rne_pkg::t_cmd o_cmd
);
    import rne_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_ERR  = 3'b100
    } t_state;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.in_range ? S_RUN : S_ERR;
                end
            end
            S_RUN: begin
                o_cmd.step = i_sts.slot_free;
                if (i_sts.slot_free && i_sts.done) begin
                    n_state = S_IDLE;
                end
            end
            S_ERR: begin
                if (i_sts.slot_free) begin
                    o_cmd.err = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/rne_datapath.sv
module rne_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic                       i_cfg_wr_data,
    input  logic [rne_pkg::NUM_W-1:0]  i_number,
    input  rne_pkg::t_cmd              i_cmd,
    output rne_pkg::t_sts              o_sts,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [rne_pkg::CHAR_W-1:0] o_out_char,
    output logic                       o_out_last,
    output logic                       o_out_oor
);
    import rne_pkg::*;

    logic              r_upper;
    logic [NUM_W-1:0]  r_num;
    logic [IDX_W-1:0]  r_idx;
    logic              r_sub;
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_last;
    logic              r_out_oor;

    logic [NUM_W-1:0]  w_weight;
    logic [NUM_W-1:0]  w_rem;
    logic [CHAR_W-1:0] w_sym;
    logic [CHAR_W-1:0] w_char;
    logic              w_hit;
    logic              w_final_sym;
    logic              w_emit;

    // table lookup and compare
    assign w_weight    = C_WEIGHT[r_idx];
    assign w_hit       = (r_num >= w_weight);
    assign w_rem       = r_num - w_weight;
    assign w_final_sym = (C_SYM1[r_idx] == NO_SYM) || r_sub;
    assign w_sym       = r_sub ? C_SYM1[r_idx] : C_SYM0[r_idx];
    assign w_char      = r_upper ? w_sym : w_sym + CASE_OFFSET;
    assign w_emit      = (i_cmd.step && w_hit) || i_cmd.err;

    assign o_sts.in_range  = (i_number != '0) && (i_number <= MAX_NUMBER);
    assign o_sts.done      = w_hit && w_final_sym && (w_rem == '0);
    assign o_sts.slot_free = !r_out_valid || i_out_ready;

    // case register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_upper <= i_cfg_wr_data;
        end
    end

    // remainder, table index and symbol select
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num <= i_number;
            r_idx <= '0;
            r_sub <= 1'b0;
        end else if (i_cmd.step) begin
            if (w_hit) begin
                if (w_final_sym) begin
                    r_sub <= 1'b0;
                    r_num <= w_rem;
                end else begin
                    r_sub <= 1'b1;
                end
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_char <= i_cmd.err ? NO_SYM : w_char;
            r_out_last <= i_cmd.err || o_sts.done;
            r_out_oor  <= i_cmd.err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;
    assign o_out_oor   = r_out_oor;

endmodule

FILE: rtl/roman_numeral_encoder_unit.sv
// Channel   Dir  Handshake                      Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready tdata[11:0] number
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata letter, tlast, tuser out of range
// cfg       in   i_cfg_wr_en                    i_cfg_wr_data upper_case
//
// A number is taken, then the table walk emits one letter on each hit and moves on one
// table entry on each miss: up to 15 letters and 12 entries passed over per number.
// An out-of-range number loads its single beat from S_ERR once the output slot is free.
// The next number is taken once the last letter sits in the output register.
// Output stalls hold the walk; reset (sync, active low) clears control, case and tvalid.
module roman_numeral_encoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [11:0] number, [15:12] zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] character
    output logic        o_m_axis_tlast,
    output logic        o_m_axis_tuser    // [0] out_of_range
);
    import rne_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    rne_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rne_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_number      (i_s_axis_tdata[NUM_W-1:0]),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_out_char    (o_m_axis_tdata),
        .o_out_last    (o_m_axis_tlast),
        .o_out_oor     (o_m_axis_tuser)
    );

`ifndef ASSERT_OFF
    // out-of-range beat is a lone zero character closing the run
    a_oor_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast && (o_m_axis_tdata == 8'd0))
        else $error("out-of-range beat malformed");

    // letters are never zero
    a_letter_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> (o_m_axis_tdata != 8'd0))
        else $error("zero letter emitted");

    // a taken number keeps the input closed in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input reopened right after accept");
`endif

endmodule

FILE: verif/roman_numeral_encoder_unit_tb.sv
`timescale 1ns / 100ps

module roman_numeral_encoder_unit_tb;

    import rne_pkg::*;

    localparam int unsigned CLK_HALF   = 2;
    localparam int unsigned RST_CYCLES = 8;
    localparam int unsigned STALL_PCT  = 10;
    // settle time covers the longest walk of one number, plus margin
    localparam int unsigned SETTLE_CYCLES = 32;
    localparam int unsigned TIMEOUT_NS    = 1_000_000;
    localparam int unsigned NUM_ENTRIES   = 13;

    // Greedy subtractive table, largest weight first, upper-case letters
    localparam int unsigned NUMERAL_WEIGHT [NUM_ENTRIES] = '{
        1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1
    };
    localparam logic [7:0] NUMERAL_HEAD [NUM_ENTRIES] = '{
        "M", "C", "D", "C", "C", "X", "L", "X", "X", "I", "V", "I", "I"
    };
    localparam logic [7:0] NUMERAL_TAIL [NUM_ENTRIES] = '{
        NO_SYM, "M", NO_SYM, "D", NO_SYM, "C", NO_SYM, "L", NO_SYM, "X",
        NO_SYM, "V", NO_SYM
    };

    typedef struct {
        logic [11:0] num;      // source number, for messages
        logic [7:0]  letter;
        logic        last;
        logic        oor;
    } letter_beat_t;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_wr_en     = 1'b0;
    logic        i_cfg_wr_data   = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata  = '0;   // [11:0] number, [15:12] zero
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;         // [7:0] character
    logic        o_m_axis_tlast;
    logic        o_m_axis_tuser;         // [0] out_of_range

    letter_beat_t expected_letters[$];
    logic         upper_case_model = 1'b0;
    bit           steady_flow      = 1'b0;
    int unsigned  error_count      = 0;

    roman_numeral_encoder_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Clock
    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #(TIMEOUT_NS);
        $display("roman_numeral_encoder_unit test failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Spell one number into the queue of expected letters
    function automatic void spell_numeral(input logic [11:0] num);
        letter_beat_t spelled[$];
        letter_beat_t beat;
        int unsigned  rest;
        int           t;
        beat.num  = num;
        beat.last = 1'b0;
        beat.oor  = 1'b0;
        rest      = num;
        if (rest < 1 || rest > MAX_NUMBER) begin
            beat.letter = NO_SYM;
            beat.last   = 1'b1;
            beat.oor    = 1'b1;
            expected_letters.push_back(beat);
            return;
        end
        for (t = 0; t < NUM_ENTRIES; t++) begin
            while (rest >= NUMERAL_WEIGHT[t]) begin
                beat.letter = NUMERAL_HEAD[t] + (upper_case_model ? 8'd0 : CASE_OFFSET);
                spelled.push_back(beat);
                if (NUMERAL_TAIL[t] != NO_SYM) begin
                    beat.letter = NUMERAL_TAIL[t] + (upper_case_model ? 8'd0 : CASE_OFFSET);
                    spelled.push_back(beat);
                end
                rest -= NUMERAL_WEIGHT[t];
            end
        end
        spelled[spelled.size() - 1].last = 1'b1;
        foreach (spelled[k]) expected_letters.push_back(spelled[k]);
    endfunction

    // Output side: random back-pressure unless steady_flow is set, and per-beat check
    always @(posedge i_clk) begin
        letter_beat_t exp_beat;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_letters.size() == 0) begin
                report_mismatch($sformatf("unexpected beat data=%h last=%b user=%b",
                    o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser));
            end else begin
                exp_beat = expected_letters.pop_front();
                if (o_m_axis_tdata !== exp_beat.letter)
                    report_mismatch($sformatf("num %0d: letter %h, expected %h",
                        exp_beat.num, o_m_axis_tdata, exp_beat.letter));
                if (o_m_axis_tlast !== exp_beat.last)
                    report_mismatch($sformatf("num %0d: tlast %b, expected %b",
                        exp_beat.num, o_m_axis_tlast, exp_beat.last));
                if (o_m_axis_tuser !== exp_beat.oor)
                    report_mismatch($sformatf("num %0d: out_of_range %b, expected %b",
                        exp_beat.num, o_m_axis_tuser, exp_beat.oor));
            end
        end
        i_m_axis_tready <= steady_flow ? 1'b1 : ($urandom_range(99) >= STALL_PCT);
    end

    // Send one number; valid stays up after the beat until the next call or a drain
    task automatic send_number(input logic [11:0] num);
        while (!steady_flow && $urandom_range(99) < STALL_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0000, num};
        do @(posedge i_clk); while (!o_s_axis_tready);
        spell_numeral(num);
    endtask

    // Stop sending and wait until every letter is out, then let the walk settle
    task automatic drain_letters();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_letters.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_case(input logic upper);
        drain_letters();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= upper;
        @(posedge i_clk);
        upper_case_model = upper;
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [11:0] pick_number();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return ($urandom_range(1) == 0) ? 12'd0 : 12'($urandom_range(4095, 4000));
        else if (roll < 20)
            // long numerals built from eights
            return 12'($urandom_range(3, 0) * 1000 + 888);
        else
            return 12'($urandom_range(MAX_NUMBER, 1));
    endfunction

    // Reset value of the case register: lower case, plus table edges
    task automatic test_reset_case();
        logic [11:0] values[$];
        values = '{12'd1, 12'd3999, 12'd3888, 12'd0, 12'd4000, 12'd4095, 12'd4, 12'd9,
                   12'd40, 12'd90, 12'd400, 12'd900, 12'd5, 12'd50, 12'd500, 12'd1000,
                   12'd2730, 12'd1365};
        foreach (values[k]) send_number(values[k]);
    endtask

    task automatic test_upper_directed();
        logic [11:0] values[$];
        write_case(1'b1);
        values = '{12'd1, 12'd3888, 12'd3999, 12'd4095, 12'd0, 12'd14, 12'd2444};
        foreach (values[k]) send_number(values[k]);
    endtask

    task automatic test_random_numbers(input logic upper, input int unsigned count);
        write_case(upper);
        repeat (count) send_number(pick_number());
    endtask

    // Sender holds off until the encoder has emptied, every few numbers
    task automatic test_paused_stream(input int unsigned count);
        int unsigned k;
        write_case(1'b0);
        for (k = 0; k < count; k++) begin
            send_number(pick_number());
            if (k % 15 == 14) drain_letters();
        end
    endtask

    task automatic test_steady_flow(input int unsigned count);
        write_case(1'b1);
        steady_flow = 1'b1;
        repeat (count) send_number(pick_number());
        drain_letters();
        steady_flow = 1'b0;
    endtask

    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_case();
        test_upper_directed();
        test_random_numbers(1'b1, 120);
        test_paused_stream(120);
        test_steady_flow(100);
        test_random_numbers(1'b0, 10);
        drain_letters();

        if (error_count == 0) begin
            $display("roman_numeral_encoder_unit test passed");
        end else begin
            $display("roman_numeral_encoder_unit test failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/rne_pkg.sv
rtl/rne_ctrl.sv
rtl/rne_datapath.sv
rtl/roman_numeral_encoder_unit.sv
verif/roman_numeral_encoder_unit_tb.sv
